>>> design/cea_pkg.sv
// Shared types and constants for the coalescing extent allocator.
// Holds table geometry, status and register codes, datapath commands and FSM states.
// No dependencies.
package cea_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W       = 18;
    localparam int ADDR_W      = 32;
    localparam int CLAIM_W     = 19;
    localparam int ENT_W       = ADDR_W + LEN_W;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    typedef enum logic [0:0] {
        CFG_UNIT_LOG2    = 1'b0,
        CFG_HEADER_UNITS = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD,
        OP_ALLOC_CHK,
        OP_FREE_CHK,
        OP_DECIDE,
        OP_DN_RD,
        OP_DN_WR,
        OP_UP_RD,
        OP_UP_WR,
        OP_INS,
        OP_CNT_DEC,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic zero;
        logic is_free;
        logic scan_end;
        logic fit;
        logic used_up;
        logic stop;
        logic dec_both;
        logic dec_insert;
        logic dn_more;
        logic up_more;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_CHK,
        S_DEC,
        S_DN_CHK,
        S_DN_RD,
        S_DN_WR,
        S_UP_CHK,
        S_UP_RD,
        S_UP_WR,
        S_INS,
        S_CNT_DEC,
        S_OUT
    } state_t;

endpackage

>>> design/cea_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/cea_ctrl.sv
// Sequencer for the extent allocator: scan, decide, shift and result hand-off.
// Depends on cea_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
module cea_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cea_pkg::dp_stat_t st,
    output cea_pkg::dp_cmd_t  cmd
);

    import cea_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (st.zero)
                begin
                    state_next = S_OUT;
                end
                else if (st.scan_end)
                begin
                    state_next = st.is_free ? S_DEC : S_OUT;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.op     = OP_RD;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (st.is_free)
                begin
                    cmd.op     = OP_FREE_CHK;
                    state_next = st.stop ? S_DEC : S_SCAN;
                end
                else
                begin
                    cmd.op = OP_ALLOC_CHK;
                    if (st.fit && st.used_up)
                    begin
                        state_next = S_DN_CHK;
                    end
                    else if (st.fit)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_DEC:
            begin
                cmd.op = OP_DECIDE;
                if (st.dec_both)
                begin
                    state_next = S_DN_CHK;
                end
                else if (st.dec_insert)
                begin
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DN_CHK:
            begin
                state_next = st.dn_more ? S_DN_RD : S_CNT_DEC;
            end
            S_DN_RD:
            begin
                cmd.op     = OP_DN_RD;
                state_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                cmd.op     = OP_DN_WR;
                state_next = S_DN_CHK;
            end
            S_UP_CHK:
            begin
                state_next = st.up_more ? S_UP_RD : S_INS;
            end
            S_UP_RD:
            begin
                cmd.op     = OP_UP_RD;
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                cmd.op     = OP_UP_WR;
                state_next = S_UP_CHK;
            end
            S_INS:
            begin
                cmd.op     = OP_INS;
                state_next = S_OUT;
            end
            S_CNT_DEC:
            begin
                cmd.op     = OP_CNT_DEC;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/cea_dp.sv
// Datapath of the extent allocator: extent table RAM, counters, totals, result register.
// Depends on cea_pkg and cea_ram; steered by cea_ctrl commands.
module cea_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [3:0]                  cfg_data,
    input  logic                        in_kind,
    input  logic [cea_pkg::ADDR_W-1:0]  in_address,
    input  logic [cea_pkg::LEN_W-1:0]   in_size,
    input  cea_pkg::dp_cmd_t            cmd,
    output cea_pkg::dp_stat_t           st,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  out_status,
    output logic [cea_pkg::ADDR_W-1:0]  out_alloc_address,
    output logic [cea_pkg::CLAIM_W-1:0] out_block_units,
    output logic [31:0]                 out_free_total,
    output logic [cea_pkg::CNT_W-1:0]   out_free_entries
);

    import cea_pkg::*;

    logic [3:0]         log2_reg;
    logic [3:0]         hdr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [31:0]        free_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic               kind_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [LEN_W-1:0]   size_reg;
    logic [ADDR_W-1:0]  prev_base_reg;
    logic [LEN_W-1:0]   prev_len_reg;
    logic [ADDR_W-1:0]  next_base_reg;
    logic [LEN_W-1:0]   next_len_reg;
    logic               has_next_reg;
    logic [1:0]         status_reg;
    logic [ADDR_W-1:0]  aout_reg;
    logic [CLAIM_W-1:0] claim_reg;
    logic               out_valid_reg;
    logic [1:0]         o_status_reg;
    logic [ADDR_W-1:0]  o_addr_reg;
    logic [CLAIM_W-1:0] o_block_reg;
    logic [31:0]        o_free_reg;
    logic [CNT_W-1:0]   o_cnt_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;

    logic [ADDR_W-1:0]  rd_base;
    logic [LEN_W-1:0]   rd_len;
    logic [CLAIM_W-1:0] claim;
    logic [ADDR_W-1:0]  new_base;
    logic [LEN_W-1:0]   new_len;
    logic [ADDR_W-1:0]  hdr_addr;
    logic [33:0]        prev_end;
    logic [33:0]        item_end;
    logic [LEN_W:0]     prev_sum;
    logic [LEN_W:0]     next_sum;
    logic [LEN_W+1:0]   both_sum;
    logic               merge_prev;
    logic               merge_next;
    logic               merge_both;
    logic               full;
    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   idx_dec;

    cea_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_base  = ram_rdata[ENT_W-1:LEN_W];
    assign rd_len   = ram_rdata[LEN_W-1:0];
    assign idx_inc  = idx_reg + 1'b1;
    assign idx_dec  = idx_reg - 1'b1;
    assign claim    = {1'b0, size_reg} + {{(CLAIM_W-4){1'b0}}, hdr_reg};
    assign new_base = rd_base + ADDR_W'({15'd0, claim} << log2_reg);
    assign new_len  = rd_len - claim[LEN_W-1:0];
    assign hdr_addr = rd_base + ADDR_W'({15'd0, hdr_reg} << log2_reg);

    // Contiguity uses the unwrapped end address.
    assign prev_end = {2'b00, prev_base_reg} + {1'b0, {15'd0, prev_len_reg} << log2_reg};
    assign item_end = {2'b00, addr_reg} + {1'b0, {15'd0, size_reg} << log2_reg};
    assign prev_sum = {1'b0, prev_len_reg} + {1'b0, size_reg};
    assign next_sum = {1'b0, next_len_reg} + {1'b0, size_reg};
    assign both_sum = {1'b0, prev_sum} + {2'b00, next_len_reg};

    assign merge_prev = (idx_reg != '0) && (prev_end == {2'b00, addr_reg})
                        && (prev_sum <= {1'b0, LEN_MAX});
    assign merge_both = merge_prev && has_next_reg && (item_end == {2'b00, next_base_reg})
                        && (both_sum <= {2'b00, LEN_MAX});
    assign merge_next = !merge_prev && has_next_reg
                        && (item_end == {2'b00, next_base_reg})
                        && (next_sum <= {1'b0, LEN_MAX});
    assign full       = (cnt_reg == CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        st.zero       = (size_reg == '0);
        st.is_free    = kind_reg;
        st.scan_end   = (idx_reg >= cnt_reg);
        st.fit        = ({1'b0, rd_len} >= claim);
        st.used_up    = (new_len <= {{(LEN_W-4){1'b0}}, hdr_reg});
        st.stop       = (rd_base > addr_reg);
        st.dec_both   = merge_both;
        st.dec_insert = !merge_prev && !merge_next && !full;
        st.dn_more    = ({1'b0, idx_reg} + 1'b1) < {1'b0, cnt_reg};
        st.up_more    = (idx_reg > pos_reg);
        st.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = idx_reg[IDX_W-1:0];
        case (cmd.op)
            OP_RD:
            begin
                ram_re = 1'b1;
            end
            OP_DN_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_inc[IDX_W-1:0];
            end
            OP_UP_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_dec[IDX_W-1:0];
            end
            OP_DN_WR, OP_UP_WR:
            begin
                ram_we = 1'b1;
            end
            OP_ALLOC_CHK:
            begin
                ram_we    = st.fit && !st.used_up;
                ram_wdata = {new_base, new_len};
            end
            OP_DECIDE:
            begin
                if (merge_prev)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_dec[IDX_W-1:0];
                    ram_wdata = {prev_base_reg,
                                 merge_both ? both_sum[LEN_W-1:0] : prev_sum[LEN_W-1:0]};
                end
                else if (merge_next)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {addr_reg, next_sum[LEN_W-1:0]};
                end
            end
            OP_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[IDX_W-1:0];
                ram_wdata = {addr_reg, size_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg      <= 4'd12;
            hdr_reg       <= 4'd0;
            cnt_reg       <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_UNIT_LOG2)
                begin
                    log2_reg <= cfg_data;
                end
                else
                begin
                    hdr_reg <= cfg_data;
                end
            end
            // Drop the beat once taken, unless a new one lands in the same cycle.
            if (out_valid_reg && out_ready && (cmd.op != OP_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_ALLOC_CHK:
                begin
                    if (st.fit)
                    begin
                        // A used-up extent drops its whole length from the total.
                        free_reg <= free_reg - (st.used_up ? {14'd0, rd_len} : {13'd0, claim});
                    end
                end
                OP_DECIDE:
                begin
                    if (merge_prev || merge_next)
                    begin
                        free_reg <= free_reg + {14'd0, size_reg};
                    end
                end
                OP_INS:
                begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    free_reg <= free_reg + {14'd0, size_reg};
                end
                OP_CNT_DEC:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                OP_OUT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                kind_reg     <= in_kind;
                addr_reg     <= in_address;
                size_reg     <= in_size;
                idx_reg      <= '0;
                has_next_reg <= 1'b0;
                aout_reg     <= '0;
                claim_reg    <= '0;
                if (in_size == '0)
                begin
                    status_reg <= ST_ZERO;
                end
                else if (in_kind)
                begin
                    status_reg <= ST_OK;
                end
                else
                begin
                    status_reg <= ST_NOFIT;
                end
            end
            OP_ALLOC_CHK:
            begin
                if (st.fit)
                begin
                    status_reg <= ST_OK;
                    aout_reg   <= hdr_addr;
                    claim_reg  <= claim;
                end
                else
                begin
                    idx_reg <= idx_inc;
                end
            end
            OP_FREE_CHK:
            begin
                if (st.stop)
                begin
                    next_base_reg <= rd_base;
                    next_len_reg  <= rd_len;
                    has_next_reg  <= 1'b1;
                end
                else
                begin
                    prev_base_reg <= rd_base;
                    prev_len_reg  <= rd_len;
                    idx_reg       <= idx_inc;
                end
            end
            OP_DECIDE:
            begin
                if (!merge_prev && !merge_next)
                begin
                    if (full)
                    begin
                        status_reg <= ST_FULL;
                    end
                    else
                    begin
                        // Open a slot at the insert point by shifting the tail up.
                        pos_reg <= idx_reg;
                        idx_reg <= cnt_reg;
                    end
                end
            end
            OP_DN_WR:
            begin
                idx_reg <= idx_inc;
            end
            OP_UP_WR:
            begin
                idx_reg <= idx_dec;
            end
            OP_OUT:
            begin
                o_status_reg <= status_reg;
                o_addr_reg   <= aout_reg;
                o_block_reg  <= claim_reg;
                o_free_reg   <= free_reg;
                o_cnt_reg    <= cnt_reg;
            end
            default:
            begin
                o_status_reg <= o_status_reg;
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = o_status_reg;
    assign out_alloc_address = o_addr_reg;
    assign out_block_units   = o_block_reg;
    assign out_free_total    = o_free_reg;
    assign out_free_entries  = o_cnt_reg;

endmodule

>>> design/coalescing_extent_allocator.sv
// Top level of the coalescing extent allocator: first-fit free list with merging.
// Depends on cea_pkg, cea_ctrl, cea_dp (which holds cea_ram).
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser: kind; tdata: address, size_units
//  m_axis    out  tvalid/tready          tdata: status, alloc_address, block_units,
//                                               free_total, free_entries
//  cfg       in   cfg_we                 cfg_index, cfg_data
//
// One item at a time: each extent scanned passes through the scan, read and check
// states, and each extent moved when an extent is removed or inserted passes through
// its check, read and write states. The extent RAM's registered read sets this pace:
// each extent is read, then checked or written in the next cycle. Reset needs no
// clearing pass. The result sits in an output register, so a stalled m_axis does not
// stop the next beat in.
module coalescing_extent_allocator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [3:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,   // address[31:0], size_units[49:32], zero pad
    input  logic [0:0]   s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata    // status[1:0], alloc_address[33:2],
                                         // block_units[52:34], free_total[84:53],
                                         // free_entries[93:85], zero pad
);

    import cea_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           st;
    logic [1:0]         o_status;
    logic [ADDR_W-1:0]  o_addr;
    logic [CLAIM_W-1:0] o_block;
    logic [31:0]        o_free;
    logic [CNT_W-1:0]   o_cnt;

    cea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cea_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_kind           (s_axis_tuser[0]),
        .in_address        (s_axis_tdata[31:0]),
        .in_size           (s_axis_tdata[49:32]),
        .cmd               (cmd),
        .st                (st),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_status        (o_status),
        .out_alloc_address (o_addr),
        .out_block_units   (o_block),
        .out_free_total    (o_free),
        .out_free_entries  (o_cnt)
    );

    assign m_axis_tdata = {2'b00, o_cnt, o_free, o_block, o_addr, o_status};

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    a_fail_no_claim: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (o_status != ST_OK) |-> (o_addr == '0) && (o_block == '0))
        else $error("failed item reports an allocation");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (o_cnt <= CNT_W'(TABLE_DEPTH)))
        else $error("extent count beyond table depth");
`endif

endmodule

>>> verif/tb_coalescing_extent_allocator.sv
// Testbench for coalescing_extent_allocator: drives allocate and free beats over the
// slave stream, predicts each result beat with an in-bench free-extent table and checks it.
// Depends on cea_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_coalescing_extent_allocator;
    import cea_pkg::*;

    localparam int DEPTH = 256;

    // first member lands in the top bits, so list from free_entries down to status
    typedef struct packed {
        logic [8:0]  free_entries;
        logic [31:0] free_total;
        logic [18:0] block_units;
        logic [31:0] alloc_address;
        logic [1:0]  status;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [3:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;

    coalescing_extent_allocator uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    // predictor state
    logic [31:0] ext_base_q [DEPTH];
    logic [17:0] ext_len_q  [DEPTH];
    int unsigned held;
    logic [31:0] free_units;
    logic [3:0]  shift_cfg;
    logic [3:0]  hdr_cfg;

    alloc_result_t pending_results[$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("tb_coalescing_extent_allocator NOT OK");
        $finish;
    end

    function automatic logic [33:0] extent_end(logic [31:0] b, logic [17:0] l);
        extent_end = {2'b00, b} + ({16'd0, l} << shift_cfg);
    endfunction

    task automatic drop_entry(int unsigned k);
        for (int unsigned j = k; j + 1 < held; j++)
        begin
            ext_base_q[j] = ext_base_q[j+1];
            ext_len_q[j]  = ext_len_q[j+1];
        end
        held--;
    endtask

    task automatic predict_beat(logic kind, logic [31:0] addr, logic [17:0] size);
        alloc_result_t r;
        logic [18:0]   claim;
        logic [33:0]   fend;
        int unsigned   i;
        bit            done;
        bit            nxt;
        r = '0;
        done = 0;
        if (size == 0)
            r.status = ST_ZERO;
        else if (kind == 1'b0)
        begin
            claim = {1'b0, size} + hdr_cfg;
            r.status = ST_NOFIT;
            for (int unsigned k = 0; k < held && !done; k++)
            begin
                if ({1'b0, ext_len_q[k]} >= claim)
                begin
                    r.status = ST_OK;
                    r.alloc_address = ext_base_q[k] + (32'(hdr_cfg) << shift_cfg);
                    r.block_units = claim;
                    ext_base_q[k] = ext_base_q[k] + (32'(claim) << shift_cfg);
                    ext_len_q[k] = ext_len_q[k] - claim[17:0];
                    free_units = free_units - claim;
                    if (ext_len_q[k] <= hdr_cfg)
                    begin
                        free_units = free_units - ext_len_q[k];
                        drop_entry(k);
                    end
                    done = 1;
                end
            end
        end
        else
        begin
            fend = extent_end(addr, size);
            i = 0;
            while (i < held && ext_base_q[i] <= addr)
                i++;
            nxt = (i < held);
            r.status = ST_OK;
            if (i > 0 && extent_end(ext_base_q[i-1], ext_len_q[i-1]) == {2'b00, addr}
                && {1'b0, ext_len_q[i-1]} + size <= 19'(LEN_MAX))
            begin
                ext_len_q[i-1] += size;
                free_units += size;
                if (nxt && fend == {2'b00, ext_base_q[i]}
                    && {1'b0, ext_len_q[i-1]} + ext_len_q[i] <= 19'(LEN_MAX))
                begin
                    ext_len_q[i-1] += ext_len_q[i];
                    drop_entry(i);
                end
                done = 1;
            end
            if (!done && nxt && fend == {2'b00, ext_base_q[i]}
                && {1'b0, ext_len_q[i]} + size <= 19'(LEN_MAX))
            begin
                ext_base_q[i] = addr;
                ext_len_q[i] += size;
                free_units += size;
                done = 1;
            end
            if (!done && held >= DEPTH)
            begin
                r.status = ST_FULL;
                done = 1;
            end
            if (!done)
            begin
                for (int unsigned j = held; j > i; j--)
                begin
                    ext_base_q[j] = ext_base_q[j-1];
                    ext_len_q[j]  = ext_len_q[j-1];
                end
                ext_base_q[i] = addr;
                ext_len_q[i] = size;
                held++;
                free_units += size;
            end
        end
        r.free_total = free_units;
        r.free_entries = 9'(held);
        pending_results.push_back(r);
    endtask

    // send one beat; waits for acceptance and leaves valid up for the next beat,
    // an idle cycle or a drain drops it
    task automatic send_beat(logic kind, logic [31:0] addr, logic [17:0] size);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'd0, size, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_beat(kind, addr, size);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [3:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_UNIT_LOG2)
            shift_cfg = val;
        else
            hdr_cfg = val;
    endtask

    // result checker
    always @(posedge clk)
    begin
        alloc_result_t got;
        alloc_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[93:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.status !== exp_r.status)
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                if (got.alloc_address !== exp_r.alloc_address)
                    $display("%0t: alloc_address exp %h got %h", $time,
                             exp_r.alloc_address, got.alloc_address);
                if (got.block_units !== exp_r.block_units)
                    $display("%0t: block_units exp %0d got %0d", $time,
                             exp_r.block_units, got.block_units);
                if (got.free_total !== exp_r.free_total)
                    $display("%0t: free_total exp %0d got %0d", $time,
                             exp_r.free_total, got.free_total);
                if (got.free_entries !== exp_r.free_entries)
                    $display("%0t: free_entries exp %0d got %0d", $time,
                             exp_r.free_entries, got.free_entries);
                if (got !== exp_r)
                    errors++;
            end
        end
    end

    // receiver backpressure; a hold count forces a long stall
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [17:0] rand_size();
        case ($urandom_range(9))
            0: rand_size = 18'($urandom);
            1: rand_size = 18'd0;
            2: rand_size = LEN_MAX;
            default: rand_size = 18'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic test_directed();
        send_beat(1'b0, 32'd0, 18'd5);                 // no fit on empty table
        send_beat(1'b1, 32'h1000, 18'd0);              // zero size free
        send_beat(1'b0, 32'd0, 18'd0);                 // zero size allocate
        send_beat(1'b1, 32'h0001_0000, 18'd4);
        send_beat(1'b1, 32'h0001_4000, 18'd4);         // append merges with predecessor
        send_beat(1'b1, 32'h0000_8000, 18'd2);         // new lower entry
        send_beat(1'b1, 32'h0000_A000, 18'd6);         // joins both sides
        send_beat(1'b1, 32'h0000_A000, 18'd1);         // same base as the previous free, overlap
        send_beat(1'b0, 32'hFFFF_FFFF, 18'd3);
        send_beat(1'b0, 32'd0, 18'd200);
        send_beat(1'b1, 32'hFFFF_F000, 18'd1);         // top of address space
        send_beat(1'b1, 32'h0200_0000, LEN_MAX);
        send_beat(1'b1, 32'h0200_0000 + (32'(LEN_MAX) << 12), 18'd1); // length overflow
        send_beat(1'b0, 32'd0, LEN_MAX);               // uses the extent up
        send_beat(1'b0, 32'd0, 18'd1);
        write_reg(CFG_HEADER_UNITS, 4'd15);
        write_reg(CFG_UNIT_LOG2, 4'd0);
        send_beat(1'b1, 32'hFFFF_FFF0, 18'd20);
        send_beat(1'b0, 32'd0, 18'd2);                 // alloc address at the top of the address space
        send_beat(1'b0, 32'd0, 18'd1);
        send_beat(1'b0, 32'd0, 18'd1);
        wait_drained();
    endtask

    // fill the table with non-contiguous extents until it reports full
    task automatic test_table_full();
        write_reg(CFG_UNIT_LOG2, 4'd3);
        write_reg(CFG_HEADER_UNITS, 4'd0);
        for (int k = 0; k < DEPTH + 4; k++)
            send_beat(1'b1, 32'h4000_0000 + 32'(k) * 32'h100, 18'd1);
        for (int k = 0; k < DEPTH + 2; k++)
            send_beat(1'b0, 32'd0, 18'd1);
        wait_drained();
    endtask

    task automatic test_random(int n);
        logic [31:0] a;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(9) < 5)
                send_beat(1'b0, 32'($urandom), rand_size());
            else
            begin
                // mostly addresses on a small grid so neighbors touch
                if ($urandom_range(9) < 8)
                    a = 32'($urandom_range(0, 63)) << (shift_cfg + 2);
                else
                    a = $urandom;
                send_beat(1'b1, a, ($urandom_range(9) == 0) ? rand_size()
                                                            : 18'($urandom_range(1, 4)));
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int k = 0; k < 12; k++)
            send_beat(1'b1, 32'h7000_0000 + 32'(k) * 32'h10000, 18'd3);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        held = 0;
        free_units = '0;
        shift_cfg = 4'd12;
        hdr_cfg = 4'd0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_table_full();
        test_backpressure();
        write_reg(CFG_UNIT_LOG2, 4'd12);
        write_reg(CFG_HEADER_UNITS, 4'd1);
        test_random(160);
        send_idle_pct = 87;
        write_reg(CFG_UNIT_LOG2, 4'd0);
        write_reg(CFG_HEADER_UNITS, 4'd0);
        test_random(150);
        send_idle_pct = 0;
        recv_stall_pct = 87;
        write_reg(CFG_UNIT_LOG2, 4'd5);
        write_reg(CFG_HEADER_UNITS, 4'd15);
        test_random(150);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        write_reg(CFG_UNIT_LOG2, 4'd12);
        write_reg(CFG_HEADER_UNITS, 4'd3);
        test_random(160);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();

        if (errors == 0 && pending_results.size() == 0)
            $display("tb_coalescing_extent_allocator OK");
        else
            $display("tb_coalescing_extent_allocator NOT OK");
        $finish;
    end

endmodule
